>>> sv/mahs_pkg.sv
package mahs_pkg;

    // frame header byte patterns
    localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
    localparam logic [7:0]  SYNC_MASK    = 8'hE0;
    localparam logic [7:0]  VERSION_MASK = 8'h18;
    localparam logic [7:0]  VERSION_RSVD = 8'h08;
    localparam logic [7:0]  LAYER_MASK   = 8'h06;
    localparam logic [7:0]  BITRATE_MASK = 8'hF0;
    localparam logic [7:0]  SRATE_MASK   = 8'h0C;
    localparam logic [15:0] DROP_MAX     = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_BYTE1 = 4'b0010,
        PH_BYTE2 = 4'b0100,
        PH_BYTE3 = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [31:0] header_word;
        logic [15:0] bytes_dropped;
    } result_t;

    // sync bits, version not reserved, layer non-zero unless allowed
    function automatic logic second_byte_ok(input logic [7:0] b, input logic allow_l4);
        second_byte_ok = ((b & SYNC_MASK) == SYNC_MASK) &&
                         ((b & VERSION_MASK) != VERSION_RSVD) &&
                         (((b & LAYER_MASK) != 8'h00) || allow_l4);
    endfunction

    // bitrate index neither free nor bad, sampling index not reserved
    function automatic logic third_byte_ok(input logic [7:0] b);
        third_byte_ok = ((b & BITRATE_MASK) != 8'h00) &&
                        ((b & BITRATE_MASK) != BITRATE_MASK) &&
                        ((b & SRATE_MASK) != SRATE_MASK);
    endfunction

endpackage

>>> sv/mahs_in_stage.sv
module mahs_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_stream_byte;
        end
    end

endmodule

>>> sv/mahs_sync_fsm.sv
module mahs_sync_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             allow_l4,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    input  logic             out_free,
    output logic             take,
    output logic             res_valid,
    output mahs_pkg::result_t res
);
    import mahs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [7:0]  held2_reg, held2_next;
    logic [15:0] drop_reg, drop_next;
    logic        is_last;
    logic        ok2, chk1, ok1;

    assign is_last   = (phase_reg == PH_BYTE3);
    // the final byte needs room in the result register
    assign take      = byte_valid && (!is_last || out_free);
    assign res_valid = take && is_last;
    assign res.header_word   = {held0_reg, held1_reg, held2_reg, byte_data};
    assign res.bytes_dropped = drop_reg;

    // recheck chain: third byte, then second byte, then first byte
    assign ok2  = (phase_reg == PH_BYTE2) && third_byte_ok(byte_data);
    assign chk1 = (phase_reg == PH_BYTE1) ||
                  ((phase_reg == PH_BYTE2) && !ok2 && (held1_reg == SYNC_BYTE));
    assign ok1  = chk1 && second_byte_ok(byte_data, allow_l4);

    always_comb begin
        phase_next = phase_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        held2_next = held2_reg;
        drop_next  = drop_reg;
        if (take) begin
            if (is_last) begin
                phase_next = PH_HUNT;
                drop_next  = '0;
            end else if (ok2) begin
                held2_next = byte_data;
                phase_next = PH_BYTE3;
            end else if (ok1) begin
                held1_next = byte_data;
                phase_next = PH_BYTE2;
            end else if (byte_data == SYNC_BYTE) begin
                held0_next = byte_data;
                phase_next = PH_BYTE1;
            end else if ((drop_reg == '0) && second_byte_ok(byte_data, allow_l4)) begin
                // missing leading sync byte, implied
                held0_next = SYNC_BYTE;
                held1_next = byte_data;
                phase_next = PH_BYTE2;
            end else begin
                if (drop_reg != DROP_MAX) begin
                    drop_next = drop_reg + 16'd1;
                end
                phase_next = PH_HUNT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            drop_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        held2_reg <= held2_next;
    end

endmodule

>>> sv/mahs_out_stage.sv
module mahs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  mahs_pkg::result_t res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_header_word,
    output logic [15:0]       m_bytes_dropped
);
    import mahs_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign out_free        = !valid_reg || m_ready;
    assign m_valid         = valid_reg;
    assign m_header_word   = res_reg.header_word;
    assign m_bytes_dropped = res_reg.bytes_dropped;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

>>> sv/mpeg_audio_header_sync.sv
// mpeg audio frame header hunter. takes one stream byte per word on the s_ channel and
// gives one word on the m_ channel for each 4-byte header found: the header with its first
// byte in bits 31..24, and the number of bytes skipped before it (saturating at 65535).
// a byte that fails a check is rechecked at the earlier search states; a lone valid second
// byte is taken with an implied 0xFF only while nothing has been dropped yet. cfg_wdata
// written with cfg_we sets allow_layer_four (accept a zero layer field); write it only
// while the block is idle. throughput is one byte per cycle, set by the single-pass check
// between the input register and the result register, except while the last byte of a
// header waits for a full result register; s_ready follows m_ready combinationally only
// then. a header word is registered in the result register as its last byte is taken.
module mpeg_audio_header_sync (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_header_word,
    output logic [15:0] m_bytes_dropped
);
    import mahs_pkg::*;

    // configuration register
    logic    allow_l4_reg;

    // links between input register, search state and result register
    logic       take;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       res_valid;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_l4_reg <= 1'b0;
        end else if (cfg_we) begin
            allow_l4_reg <= cfg_wdata;
        end
    end

    // input register, freed as the search logic consumes the byte
    mahs_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .take          (take),
        .byte_valid    (byte_valid),
        .byte_data     (byte_data)
    );

    // header search state and checks, one byte per pass
    mahs_sync_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .allow_l4   (allow_l4_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register towards the m_ side
    mahs_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .res_valid       (res_valid),
        .res             (res),
        .out_free        (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_header_word   (m_header_word),
        .m_bytes_dropped (m_bytes_dropped)
    );

endmodule

>>> sv/mahs_checker.sv
module mahs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_header_word,
    input logic [15:0] m_bytes_dropped
);
    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_header_word) &&
                                $stable(m_bytes_dropped))
        else $error("result word changed while stalled");

    // first byte and sync bits of any header
    a_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_header_word[31:24] == 8'hFF) && (m_header_word[23:21] == 3'b111) &&
                    (m_header_word[20:19] != 2'b01))
        else $error("header without sync pattern");

    // bitrate and sampling index of the third byte
    a_third: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_header_word[15:12] != 4'h0) && (m_header_word[15:12] != 4'hF) &&
                    (m_header_word[11:10] != 2'b11))
        else $error("header with bad third byte");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

bind mpeg_audio_header_sync mahs_checker u_mahs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_header_word   (m_header_word),
    .m_bytes_dropped (m_bytes_dropped)
);
